[rtl/lru_key_value_cache_unit_assert.svh]
// Assertion macros shared by the cache RTL modules.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while the active-low reset is asserted.
`define LKVC_ASSERT_RST(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that is always on.
`define LKVC_ASSERT(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LKVC_ASSERT_RST(name, clk, rstn, prop, msg)
`define LKVC_ASSERT(name, clk, prop, msg)

`endif

`endif

[rtl/lkvc_pkg.sv]
// Types, widths and codes for the LRU key-value cache.
// Used by every module of the cache; depends on nothing.
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 31;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } entry_t;

    typedef struct packed {
        logic                    hit_move;
        logic                    insert;
        logic signed [KEY_W-1:0] key;
    } cell_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } result_t;

endpackage

[rtl/lru_key_value_cache_unit.sv]
// LRU key-value cache top level: a chain of recency cells, slot 0 most recent.
// Throughput: one request per cycle while s_ready is high.
// Timing is set by one key compare across all cells plus the shift into each cell.
// Up to two get results are buffered before s_ready drops.
// Reset (aresetn, synchronous): store empty, capacity 16, no clearing pass.
// Depends on lkvc_pkg, lkvc_cell, lkvc_out_buf and the assertion macro header.
`include "lru_key_value_cache_unit_assert.svh"
module lru_key_value_cache_unit import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_cmd,
    input  logic signed [KEY_W-1:0] s_key,
    input  logic [VAL_W-1:0]        s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic [VAL_W-1:0]        m_read_value
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] cap_cfg_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CMP_W-1:0] cap_ext, max_ext, eff_ext;
    logic [CNT_W-1:0] eff_cap;

    logic             accept;
    logic             hit;
    logic [VAL_W-1:0] hit_value;
    cell_ctl_t        ctl;
    entry_t           front;
    result_t          res;
    result_t          out_data;

    entry_t           entries [MAX_ENTRIES];
    logic             seen    [MAX_ENTRIES+1];
    logic [VAL_W-1:0] rd      [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] valid_vec;

    assign cap_ext = CMP_W'(cap_cfg_reg);
    assign max_ext = CMP_W'(MAX_ENTRIES);
    assign eff_ext = (cap_ext == '0) ? CMP_W'(1) : ((cap_ext > max_ext) ? max_ext : cap_ext);
    assign eff_cap = CNT_W'(eff_ext);

    assign accept    = s_valid && s_ready;
    assign seen[0]   = 1'b0;
    assign rd[0]     = '0;
    assign hit       = seen[MAX_ENTRIES];
    assign hit_value = rd[MAX_ENTRIES];

    assign ctl.hit_move = accept && hit;
    assign ctl.insert   = accept && (s_cmd == CMD_PUT) && !hit;
    assign ctl.key      = s_key;

    assign front.valid = 1'b1;
    assign front.key   = s_key;
    assign front.value = (s_cmd == CMD_PUT) ? s_value : hit_value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            lkvc_cell #(
                .MAX_ENTRIES (MAX_ENTRIES),
                .INDEX       (gi)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .cap      (eff_cap),
                .front    (front),
                .prev     ((gi == 0) ? front : entries[(gi == 0) ? 0 : gi-1]),
                .seen_in  (seen[gi]),
                .rd_in    (rd[gi]),
                .entry    (entries[gi]),
                .match    (match_vec[gi]),
                .seen_out (seen[gi+1]),
                .rd_out   (rd[gi+1])
            );
            assign valid_vec[gi] = entries[gi].valid;
        end
    endgenerate

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.insert) begin
            cnt_next = (cnt_reg >= eff_cap) ? eff_cap : CNT_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            cap_cfg_reg <= CAP_RESET;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_we) begin
                cap_cfg_reg <= cfg_wdata;
            end
        end
    end

    assign res.hit        = hit;
    assign res.read_value = hit_value;

    lkvc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && (s_cmd == CMD_GET)),
        .push_data (res),
        .room      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_hit        = out_data.hit;
    assign m_read_value = out_data.read_value;

    `LKVC_ASSERT_RST(a_count_matches_valid, aclk, aresetn, $countones(valid_vec) == int'(cnt_reg), "entry count disagrees with valid cells")
    `LKVC_ASSERT_RST(a_valid_packed, aclk, aresetn, (valid_vec & (valid_vec + 1'b1)) == '0, "valid entries not packed at the recent end")
    `LKVC_ASSERT_RST(a_key_unique, aclk, aresetn, $onehot0(match_vec), "key held in more than one cell")
    `LKVC_ASSERT_RST(a_get_gives_result, aclk, aresetn, (accept && (s_cmd == CMD_GET)) |=> m_valid, "get request produced no result")

endmodule

[rtl/lkvc_cell.sv]
// One recency slot of the cache: holds an entry, compares it to the request key
// and shifts from its younger neighbor. Depends on lkvc_pkg.
module lkvc_cell import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int INDEX       = 0,
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] cap,
    input  entry_t           front,
    input  entry_t           prev,
    input  logic             seen_in,
    input  logic [VAL_W-1:0] rd_in,
    output entry_t           entry,
    output logic             match,
    output logic             seen_out,
    output logic [VAL_W-1:0] rd_out
);

    logic                    valid_reg, valid_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0]        val_reg, val_next;

    assign match    = valid_reg && (key_reg == ctl.key);
    assign seen_out = seen_in | match;
    assign rd_out   = rd_in | (match ? val_reg : '0);
    assign entry    = '{valid: valid_reg, key: key_reg, value: val_reg};

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        if (INDEX == 0) begin
            if (ctl.hit_move || ctl.insert) begin
                valid_next = front.valid;
                key_next   = front.key;
                val_next   = front.value;
            end
        end else if ((ctl.hit_move && !seen_in) ||
                     (ctl.insert && (CNT_W'(INDEX) < cap))) begin
            valid_next = prev.valid;
            key_next   = prev.key;
            val_next   = prev.value;
        end else if (ctl.insert) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

endmodule

[rtl/lkvc_out_buf.sv]
// Two-deep result buffer (output register plus skid) for get responses.
// Depends on lkvc_pkg and the assertion macro header.
`include "lru_key_value_cache_unit_assert.svh"
module lkvc_out_buf import lkvc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop     = main_valid_reg && m_ready;
    assign room    = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                main_next = push_data;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg) begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end else begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `LKVC_ASSERT_RST(a_skid_behind_main, aclk, aresetn, skid_valid_reg |-> main_valid_reg, "skid holds a result while the output register is empty")
    `LKVC_ASSERT_RST(a_no_overflow, aclk, aresetn, skid_valid_reg |-> !push, "result pushed into a full buffer")
    `LKVC_ASSERT_RST(a_skid_drains, aclk, aresetn, (skid_valid_reg && m_ready) |=> !skid_valid_reg, "skid not drained after output taken")

endmodule
